// ===== rtl/assert_macros.svh =====
// Assertion helpers, compiled out when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ACRF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

`define ACRF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`else

`define ACRF_ASSERT_NOW(lbl, ante, cons)

`define ACRF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/acrf_pkg.sv =====
package acrf_pkg;

	localparam int MAX_REGIONS = 64;
	localparam int IDX_W       = $clog2(MAX_REGIONS);
	localparam int CNT_W       = 7;
	localparam int ADDR_W      = 64;
	localparam int PAGES_W     = 52;
	localparam int PAGE_SHIFT  = 12;
	localparam int IN_W        = 368;
	localparam int OUT_W       = 64;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef struct packed {
		logic               free;
		logic [PAGES_W-1:0] pages;
		logic [ADDR_W-1:0]  base;
	} entry_t;

	typedef struct packed {
		logic               start;
		logic [ADDR_W-1:0]  lo;
		logic [ADDR_W-1:0]  hi;
		logic [ADDR_W-1:0]  align;
		logic [PAGES_W-1:0] need_pages;
		logic [CNT_W-1:0]   limit;
	} srch_req_t;

	typedef struct packed {
		logic              idle;
		logic              done;
		logic              found;
		logic [ADDR_W-1:0] base;
	} walk_stat_t;

endpackage

// ===== rtl/acrf_mem.sv =====
module acrf_mem (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [acrf_pkg::IDX_W-1:0]  wr_addr,
	input  acrf_pkg::entry_t            wr_data,
	input  logic                        rd_en,
	input  logic [acrf_pkg::IDX_W-1:0]  rd_addr,
	output acrf_pkg::entry_t            rd_data
);
	import acrf_pkg::*;

	entry_t mem_q [MAX_REGIONS];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/acrf_walk.sv =====
module acrf_walk (
	input  logic                        clk,
	input  logic                        arst_n,
	input  acrf_pkg::srch_req_t         req,
	input  logic                        take,
	output acrf_pkg::walk_stat_t        stat,
	output logic                        rd_en,
	output logic [acrf_pkg::IDX_W-1:0]  rd_addr,
	input  acrf_pkg::entry_t            rd_data
);
	import acrf_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_next;
	logic [CNT_W-1:0]   limit_q;
	logic [ADDR_W-1:0]  lo_q;
	logic [ADDR_W-1:0]  hi_q;
	logic [ADDR_W-1:0]  mask_q;
	logic [ADDR_W-1:0]  need_q;
	logic               need_nz_q;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic               pipe_busy;

	logic [ADDR_W-1:0]  re_s1;
	logic [ADDR_W-1:0]  rb_s2, re_s2;
	logic               free_s2;
	logic               skip_s2;
	logic [ADDR_W-1:0]  crb_s2, cre_s2;
	logic [ADDR_W-1:0]  crb_s3, cre_s3;
	logic               brk_s3, join_s3;

	logic               have_run_q;
	logic [ADDR_W-1:0]  run_base_q, run_end_q;

	logic [ADDR_W-1:0]  cand_s5, base_s5, end_s5;
	logic               match_s5;

	logic               hit_q;
	logic [ADDR_W-1:0]  hit_base_q;

	assign cnt_next  = cnt_q + CNT_W'(1);
	assign rd_en     = (state_q == ST_RUN);
	assign rd_addr   = IDX_W'(cnt_q);
	assign pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						cnt_q   <= '0;
						state_q <= (req.limit == '0) ? ST_DRAIN : ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_next;
					if (cnt_next == limit_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Search parameters, latched on start
	always_ff @(posedge clk) begin
		if (req.start && state_q == ST_IDLE) begin
			limit_q   <= req.limit;
			lo_q      <= req.lo;
			hi_q      <= req.hi;
			mask_q    <= req.align - ADDR_W'(1);
			need_q    <= {req.need_pages, {PAGE_SHIFT{1'b0}}};
			need_nz_q <= (req.need_pages != '0);
		end
	end

	// Stage 1: region end
	assign re_s1 = rd_data.base + {rd_data.pages, {PAGE_SHIFT{1'b0}}};

	always_ff @(posedge clk) begin
		rb_s2   <= rd_data.base;
		re_s2   <= re_s1;
		free_s2 <= rd_data.free;
	end

	// Stage 2: window test and clip
	assign skip_s2 = (re_s2 <= lo_q) || (rb_s2 >= hi_q) || (re_s2 <= rb_s2) || (hi_q <= lo_q);
	assign crb_s2  = (rb_s2 < lo_q) ? lo_q : rb_s2;
	assign cre_s2  = (re_s2 > hi_q) ? hi_q : re_s2;

	always_ff @(posedge clk) begin
		crb_s3  <= crb_s2;
		cre_s3  <= cre_s2;
		brk_s3  <= !free_s2;
		join_s3 <= free_s2 && !skip_s2;
	end

	// Stage 3: run update; stage 4: align; stage 5: fit check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
			have_run_q <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && join_s3;
			v_s5 <= v_s4;
			if (req.start && state_q == ST_IDLE) begin
				have_run_q <= 1'b0;
				hit_q      <= 1'b0;
			end else begin
				if (v_s3 && brk_s3) begin
					have_run_q <= 1'b0;
				end else if (v_s3 && join_s3) begin
					have_run_q <= 1'b1;
				end
				if (v_s5 && match_s5) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && join_s3) begin
			if (!have_run_q || crb_s3 > run_end_q) begin
				run_base_q <= crb_s3;
				run_end_q  <= cre_s3;
			end else if (cre_s3 > run_end_q) begin
				run_end_q <= cre_s3;
			end
		end
		cand_s5 <= (run_base_q + mask_q) & ~mask_q;
		base_s5 <= run_base_q;
		end_s5  <= run_end_q;
		if (v_s5 && match_s5 && !hit_q) begin
			hit_base_q <= cand_s5;
		end
	end

	assign match_s5 = need_nz_q && (cand_s5 >= base_s5) && (cand_s5 <= end_s5)
		&& ((end_s5 - cand_s5) >= need_q);

	assign stat.idle  = (state_q == ST_IDLE);
	assign stat.done  = (state_q == ST_DONE);
	assign stat.found = hit_q;
	assign stat.base  = hit_base_q;

endmodule

// ===== rtl/aligned_contiguous_range_finder_core.sv =====
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser opcode, tdata entry and search fields
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser found, tdata found_base
// cfg       in   cfg_valid/cfg_ready          cfg_data region_count
//
// A load is written to the table when accepted and does not block the next item. A search
// walks min(region_count, 64) entries, one per cycle, then a five-stage pipeline drains:
// the result goes to the output register, and the next item is taken once the walker is
// idle again. Items are taken only while the walker is idle; a result waiting
// in the output register holds the next finished search, which then blocks input.
// Reset clears control state only; table entries stay undefined until loaded.
`include "assert_macros.svh"

module aligned_contiguous_range_finder_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// [5:0] entry_index, [69:6] entry_base, [121:70] entry_pages, [122] entry_free,
	// [186:123] min_address, [250:187] max_address, [314:251] alignment,
	// [366:315] pages_needed, [367] zero
	input  logic [acrf_pkg::IN_W-1:0]  s_axis_tdata,
	// [0] opcode
	input  logic                       s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// [63:0] found_base
	output logic [acrf_pkg::OUT_W-1:0] m_axis_tdata,
	// [0] found
	output logic                       m_axis_tuser,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [acrf_pkg::CNT_W-1:0] cfg_data
);
	import acrf_pkg::*;

	logic               s_acc;
	logic               wr_en;
	entry_t             wr_data;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	entry_t             rd_data;
	srch_req_t          req;
	walk_stat_t         stat;
	logic               res_take;
	logic [CNT_W-1:0]   region_count_q;
	logic               out_valid_q;
	logic               out_found_q;
	logic [OUT_W-1:0]   out_base_q;

	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = stat.idle;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			region_count_q <= cfg_data;
		end
	end

	assign wr_en = s_acc && (s_axis_tuser == OP_LOAD)
		&& (32'(s_axis_tdata[5:0]) < MAX_REGIONS);
	assign wr_data.base  = s_axis_tdata[69:6];
	assign wr_data.pages = s_axis_tdata[121:70];
	assign wr_data.free  = s_axis_tdata[122];

	assign req.start      = s_acc && (s_axis_tuser == OP_SEARCH);
	assign req.lo         = s_axis_tdata[186:123];
	assign req.hi         = s_axis_tdata[250:187];
	assign req.align      = s_axis_tdata[314:251];
	assign req.need_pages = s_axis_tdata[366:315];
	assign req.limit      = (32'(region_count_q) > MAX_REGIONS) ? CNT_W'(MAX_REGIONS)
		: region_count_q;

	acrf_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (IDX_W'(s_axis_tdata[5:0])),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	acrf_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.take    (res_take),
		.stat    (stat),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign res_take = stat.done && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_found_q <= stat.found;
			out_base_q  <= stat.found ? stat.base : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_base_q;
	assign m_axis_tuser  = out_found_q;

	`ACRF_ASSERT_NOW(a_ready_not_done, s_axis_tready, !stat.done)
	`ACRF_ASSERT_NEXT(a_take_shows_result, res_take, m_axis_tvalid)
	`ACRF_ASSERT_NEXT(a_search_blocks_input, req.start, !s_axis_tready)
	`ACRF_ASSERT_NOW(a_miss_zero_base, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)

endmodule

// ===== verif/aligned_contiguous_range_finder_core_tb.sv =====
`timescale 1ns / 1ps

module aligned_contiguous_range_finder_core_tb;

	import acrf_pkg::*;

	localparam int QUIET_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_CYCLES  = 1500;
	localparam int PHASE_ITEMS  = 45;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] base;
	} range_result_t;

	class range_scoreboard;
		logic [ADDR_W-1:0]  base_tbl[MAX_REGIONS];
		logic [PAGES_W-1:0] pages_tbl[MAX_REGIONS];
		logic               free_tbl[MAX_REGIONS];
		logic [CNT_W-1:0]   region_count;
		range_result_t      expected_q[$];
		int                 mismatches;

		function new();
			region_count = '0;
			mismatches   = 0;
		endfunction

		function void set_count(logic [CNT_W-1:0] value);
			region_count = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function int walk_limit();
			return (region_count > MAX_REGIONS) ? MAX_REGIONS : int'(region_count);
		endfunction

		// first-fit walk over the table, run base aligned up after each joining entry
		function range_result_t first_fit(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi,
			logic [ADDR_W-1:0] align, logic [PAGES_W-1:0] pages);
			logic [ADDR_W-1:0] need, run_base, run_end, rb, re, cand, mask;
			bit                have_run;
			range_result_t     res;
			res      = '0;
			need     = {pages, 12'h000};
			run_base = '0;
			run_end  = '0;
			have_run = 0;
			mask     = align - 64'd1;
			if (need == '0)
				return res;
			for (int i = 0; i < walk_limit(); i++) begin
				if (!free_tbl[i]) begin
					have_run = 0;
					continue;
				end
				rb = base_tbl[i];
				re = rb + {pages_tbl[i], 12'h000};
				if (re <= lo || rb >= hi)
					continue;
				if (rb < lo)
					rb = lo;
				if (re > hi)
					re = hi;
				if (re <= rb)
					continue;
				if (!have_run || rb > run_end) begin
					run_base = rb;
					run_end  = re;
					have_run = 1;
				end else if (re > run_end) begin
					run_end = re;
				end
				cand = (run_base + mask) & ~mask;
				if (cand >= run_base && cand <= run_end && run_end - cand >= need) begin
					res.found = 1'b1;
					res.base  = cand;
					return res;
				end
			end
			return res;
		endfunction

		function void note_item(logic op, logic [IN_W-1:0] d);
			if (op == OP_LOAD) begin
				base_tbl[d[5:0]]  = d[69:6];
				pages_tbl[d[5:0]] = d[121:70];
				free_tbl[d[5:0]]  = d[122];
			end else begin
				expected_q.push_back(first_fit(d[186:123], d[250:187], d[314:251], d[366:315]));
			end
		endfunction

		function void flag(string what, range_result_t want, range_result_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("%t mismatch (%s): expected found=%0b base=%h, got found=%0b base=%h",
					$realtime, what, want.found, want.base, got.found, got.base);
		endfunction

		function void check_result(logic found, logic [ADDR_W-1:0] base);
			range_result_t got, want;
			got.found = found;
			got.base  = base;
			want      = '0;
			if (expected_q.size() == 0) begin
				flag("no search outstanding", want, got);
				return;
			end
			want = expected_q.pop_front();
			if (got.found !== want.found || got.base !== want.base)
				flag("search result", want, got);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [IN_W-1:0]    s_axis_tdata = '0;
	logic               s_axis_tuser = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [OUT_W-1:0]   m_axis_tdata;
	logic               m_axis_tuser;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CNT_W-1:0]   cfg_data = '0;

	range_scoreboard sb = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_req       = 0;

	aligned_contiguous_range_finder_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// transfers are observed mid-cycle; they complete at the next rising edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_count(cfg_data);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_item(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tuser, m_axis_tdata);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [IN_W-1:0] pack_item(logic [IDX_W-1:0] idx,
		logic [ADDR_W-1:0] base, logic [PAGES_W-1:0] pages, logic free,
		logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi, logic [ADDR_W-1:0] align,
		logic [PAGES_W-1:0] need);
		return {1'b0, need, align, hi, lo, free, pages, base, idx};
	endfunction

	task automatic send_transfer(input logic op, input logic [IN_W-1:0] data);
		bit ok;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= data;
		do begin
			@(negedge clk);
			ok = s_axis_tready;
			@(posedge clk);
		end while (!ok);
	endtask

	task automatic load_item(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] base,
		input logic [PAGES_W-1:0] pages, input logic free);
		send_transfer(OP_LOAD, pack_item(idx, base, pages, free, '0, '0, '0, '0));
	endtask

	task automatic search_item(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi,
		input logic [ADDR_W-1:0] align, input logic [PAGES_W-1:0] need);
		send_transfer(OP_SEARCH, pack_item('0, '0, '0, 1'b0, lo, hi, align, need));
	endtask

	// block idle: stream stopped, every result back, in-flight load retired
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] value);
		bit ok;
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
	endtask

	// mostly chained free regions, some overlapping, gapped, busy or unaligned
	task automatic load_layout();
		logic [ADDR_W-1:0]  next_base;
		logic [PAGES_W-1:0] pg;
		int                 r;
		next_base = ($urandom_range(9) == 0) ? 64'hFFFF_FFFF_FFF0_0000 : rand64() & ~64'hFFF;
		for (int i = 0; i < MAX_REGIONS; i++) begin
			pg = PAGES_W'($urandom_range(1, 16));
			r  = $urandom_range(9);
			load_item(IDX_W'(i),
				next_base + ADDR_W'((r == 9) ? $urandom_range(1, 4095) : 0), pg,
				$urandom_range(7) != 0);
			if (r < 5)
				next_base += {pg, 12'h000};
			else if (r < 7)
				next_base += {pg, 12'h000} - 64'($urandom_range(1, 4) << 12);
			else
				next_base += {pg, 12'h000} + 64'($urandom_range(1, 8) << 12);
		end
	endtask

	task automatic shaped_search();
		logic [ADDR_W-1:0]  lo, hi, align;
		logic [PAGES_W-1:0] need;
		int                 lim, j, r;
		lim = (sb.walk_limit() == 0) ? 1 : sb.walk_limit();
		j   = $urandom_range(0, lim - 1);
		lo  = ($urandom_range(9) == 0) ? 64'd0 :
			sb.base_tbl[j] - 64'($urandom_range(0, 3) << 12);
		r = $urandom_range(9);
		if (r < 8)
			hi = lo + 64'($urandom_range(1, 256) << 12);
		else if (r == 8)
			hi = '1;
		else
			hi = lo - 64'($urandom_range(0, 4096));
		r = $urandom_range(9);
		if (r < 7)
			align = 64'd1 << $urandom_range(0, 20);
		else if (r == 7)
			align = '0;
		else if (r == 8)
			align = ADDR_W'($urandom_range(0, 4095) | 1);
		else
			align = rand64();
		r = $urandom_range(9);
		if (r < 8)
			need = PAGES_W'($urandom_range(1, 16));
		else if (r == 8)
			need = '0;
		else
			need = PAGES_W'(rand64());
		search_item(lo, hi, align, need);
	endtask

	task automatic random_item();
		int                r, j;
		logic [IN_W-1:0]   noise;
		r = $urandom_range(99);
		if (r < 70) begin
			shaped_search();
		end else if (r < 85) begin
			j = $urandom_range(0, MAX_REGIONS - 1);
			load_item(IDX_W'(j), sb.base_tbl[j], PAGES_W'($urandom_range(1, 16)),
				1'($urandom_range(1)));
		end else begin
			for (int k = 0; k < IN_W; k += 32)
				noise[k +: 32] = $urandom;
			noise[IN_W-1] = 1'b0;
			send_transfer(1'($urandom_range(1)), noise);
		end
	endtask

	initial begin
		logic [CNT_W-1:0] phase_count[8];
		phase_count = '{7'd64, 7'd1, 7'd127, 7'd64, 7'd45, 7'd13, 7'd64, 7'd100};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table walk, then a small hand-built table
		write_count(7'd0);
		search_item(64'd0, '1, 64'd1, 52'd1);
		load_item(6'd0, 64'h1000, 52'd4, 1'b1);
		load_item(6'd1, 64'h5000, 52'd4, 1'b1);
		load_item(6'd2, 64'h2_0000, 52'd2, 1'b0);
		load_item(6'd3, 64'hFFFF_FFFF_FFFF_F000, 52'd2, 1'b1);
		load_item(6'd4, '1, '1, 1'b1);
		drain();
		write_count(7'd5);
		search_item(64'd0, '1, 64'h1000, 52'd8);
		search_item(64'd0, '1, 64'h1000, 52'd0);
		search_item(64'd0, '1, 64'h1000, '1);
		search_item(64'd0, '1, 64'd0, 52'd1);
		search_item(64'd0, '1, '1, 52'd1);
		search_item(64'd0, '1, 64'd3, 52'd2);
		search_item(64'd0, '1, 64'h1_0000, 52'd1);
		search_item(64'h3000, 64'h6000, 64'h1000, 52'd3);
		search_item(64'h2000, 64'h2000, 64'd1, 52'd1);
		search_item('1, 64'd0, 64'd1, 52'd1);
		search_item(64'h1800, '1, 64'h800, 52'd1);
		search_item(64'h6000, 64'hA000, 64'h1000, 52'd3);

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			if (p % 4 == 0)
				load_layout();
			drain();
			write_count(phase_count[p]);
			if (p == 1) begin
				// output held off while searches keep coming
				hold_req = 1;
				repeat (20) shaped_search();
			end
			repeat (PHASE_ITEMS) random_item();
		end

		drain();
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
